FILE: sv/tpr_pkg.sv
// ----------------------------------------------------------------------------
// tpr_pkg
// Shared sizes, codes and helpers of the trajectory point reassembler.
// ----------------------------------------------------------------------------
package tpr_pkg;

    localparam int ARMS       = 2;
    localparam int POINTS     = 16;
    localparam int JOINTS     = 6;
    localparam int OUT_JOINTS = 6;

    localparam int SLOTS   = ARMS * POINTS;
    localparam int MOTORS  = ARMS * JOINTS;
    localparam int ARM_W   = (ARMS > 1) ? $clog2(ARMS) : 1;
    localparam int JOINT_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int POS_W  = 32;
    localparam int TIME_W = 64;

    localparam logic [3:0]  MIN_LENGTH = 4'd8;
    localparam logic [7:0]  FINAL_MARK = 8'h01;

    localparam int          CFG_IDX_W    = 1;
    localparam int          CFG_DATA_W   = 11;
    localparam logic [10:0] FRAME_ID_RST = 11'd256;
    localparam logic        BUS_RST      = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_ID = 1'b0,
        CFG_BUS      = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IGNORED   = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_MOTOR = 3'd2,
        ST_BAD_POINT = 3'd3,
        ST_STORED    = 3'd4,
        ST_COMPLETE  = 3'd5
    } t_status;

    typedef logic [JOINTS-1:0][POS_W-1:0] t_joint_row;

    typedef struct packed {
        logic                  store;
        t_status               status;
        logic [ARM_W-1:0]      arm;
        logic [JOINT_W-1:0]    joint;
        logic [SLOT_W-1:0]     slot;
    } t_decode;

    // arm of a motor code known to be below MOTORS
    function automatic logic [ARM_W-1:0] motor_arm(input logic [7:0] motor);
        logic [ARM_W-1:0] arm;
        arm = '0;
        for (int a = 1; a < ARMS; a++) begin
            if (motor >= 8'(a * JOINTS)) begin
                arm = ARM_W'(a);
            end
        end
        return arm;
    endfunction

endpackage

FILE: sv/tpr_in_if.sv
// ----------------------------------------------------------------------------
// tpr_in_if
// Received frame channel: valid/ready handshake with the frame fields.
// ----------------------------------------------------------------------------
interface tpr_in_if;
    logic        valid;
    logic        ready;
    logic        bus_index;
    logic [10:0] frame_id;
    logic [3:0]  frame_length;
    logic [7:0]  point_byte;
    logic [7:0]  motor_byte;
    logic [31:0] position_word;
    logic [7:0]  final_byte;
    logic [63:0] arrival_time;

    modport source (
        output valid, bus_index, frame_id, frame_length, point_byte,
               motor_byte, position_word, final_byte, arrival_time,
        input  ready
    );

    modport sink (
        input  valid, bus_index, frame_id, frame_length, point_byte,
               motor_byte, position_word, final_byte, arrival_time,
        output ready
    );
endinterface

FILE: sv/tpr_out_if.sv
// ----------------------------------------------------------------------------
// tpr_out_if
// Result channel: valid/ready handshake with status and assembled point.
// ----------------------------------------------------------------------------
interface tpr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        arm_index;
    logic [3:0]  point_index;
    logic [31:0] joint_zero;
    logic [31:0] joint_one;
    logic [31:0] joint_two;
    logic [31:0] joint_three;
    logic [31:0] joint_four;
    logic [31:0] joint_five;
    logic        final_point;
    logic [63:0] point_time;

    modport source (
        output valid, status, arm_index, point_index, joint_zero, joint_one,
               joint_two, joint_three, joint_four, joint_five, final_point,
               point_time,
        input  ready
    );

    modport sink (
        input  valid, status, arm_index, point_index, joint_zero, joint_one,
               joint_two, joint_three, joint_four, joint_five, final_point,
               point_time,
        output ready
    );
endinterface

FILE: sv/trajectory_point_reassembler.sv
// ----------------------------------------------------------------------------
// trajectory_point_reassembler
// Collects per-joint trajectory frames into complete points.
// ----------------------------------------------------------------------------
// result: each beat is registered in stage 1, then in the output registers
// throughput: one beat per cycle if not stalled, set by one row read per beat
// the row read misses the same beat's lane write; that lane is bypassed
// reset: config to defaults, received and final flags cleared at once
// joint memory is not cleared; a point only completes from written lanes
module trajectory_point_reassembler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tpr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tpr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    tpr_in_if.sink                            i_frame,
    tpr_out_if.source                         o_result
);

    logic [10:0]              r_cfg_frame_id;
    logic                     r_cfg_bus;

    logic [tpr_pkg::JOINTS-1:0] r_recv [tpr_pkg::SLOTS];
    logic                       r_fin  [tpr_pkg::SLOTS];

    tpr_pkg::t_decode         w_dec;
    tpr_pkg::t_joint_row      w_rd_row;
    logic                     w_accept;
    logic                     w_s1_move;
    logic [tpr_pkg::JOINTS-1:0] n_recv;
    logic                     n_fin;
    logic                     n_complete;

    logic                       r_s1_valid;
    tpr_pkg::t_status           r_s1_status;
    logic                       r_s1_arm;
    logic [3:0]                 r_s1_point;
    logic [tpr_pkg::JOINT_W-1:0] r_s1_lane;
    logic [tpr_pkg::POS_W-1:0]  r_s1_pos;
    logic                       r_s1_final;
    logic [tpr_pkg::TIME_W-1:0] r_s1_time;

    logic [tpr_pkg::POS_W-1:0]  n_joint [tpr_pkg::OUT_JOINTS];

    logic                       r_out_valid;
    logic [2:0]                 r_out_status;
    logic                       r_out_arm;
    logic [3:0]                 r_out_point;
    logic [tpr_pkg::POS_W-1:0]  r_out_joint [tpr_pkg::OUT_JOINTS];
    logic                       r_out_final;
    logic [tpr_pkg::TIME_W-1:0] r_out_time;

    tpr_decode u_decode (
        .i_bus_index    (i_frame.bus_index),
        .i_frame_id     (i_frame.frame_id),
        .i_frame_length (i_frame.frame_length),
        .i_point_byte   (i_frame.point_byte),
        .i_motor_byte   (i_frame.motor_byte),
        .i_cfg_frame_id (r_cfg_frame_id),
        .i_cfg_bus      (r_cfg_bus),
        .o_dec          (w_dec)
    );

    assign w_s1_move      = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_frame.ready  = !r_s1_valid || w_s1_move;
    assign w_accept       = i_frame.valid && i_frame.ready;

    tpr_joint_ram u_joint_ram (
        .i_clk     (i_clk),
        .i_we      (w_accept && w_dec.store),
        .i_re      (w_accept),
        .i_slot    (w_dec.slot),
        .i_lane    (w_dec.joint),
        .i_wr_data (i_frame.position_word),
        .o_rd_row  (w_rd_row)
    );

    // flag read-modify-write in the beat cycle
    always_comb begin
        n_recv     = r_recv[w_dec.slot] | (tpr_pkg::JOINTS'(1) << w_dec.joint);
        n_fin      = r_fin[w_dec.slot] || (i_frame.final_byte == tpr_pkg::FINAL_MARK);
        n_complete = (n_recv == {tpr_pkg::JOINTS{1'b1}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_frame_id <= tpr_pkg::FRAME_ID_RST;
            r_cfg_bus      <= tpr_pkg::BUS_RST;
        end else if (i_cfg_we) begin
            case (tpr_pkg::t_cfg_reg'(i_cfg_index))
                tpr_pkg::CFG_FRAME_ID: r_cfg_frame_id <= i_cfg_data[10:0];
                tpr_pkg::CFG_BUS:      r_cfg_bus      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < tpr_pkg::SLOTS; s++) begin
                r_recv[s] <= '0;
                r_fin[s]  <= 1'b0;
            end
        end else if (w_accept && w_dec.store) begin
            r_recv[w_dec.slot] <= n_complete ? '0 : n_recv;
            r_fin[w_dec.slot]  <= n_complete ? 1'b0 : n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status <= (w_dec.store && n_complete) ? tpr_pkg::ST_COMPLETE : w_dec.status;
            r_s1_arm    <= w_dec.arm[0];
            r_s1_point  <= i_frame.point_byte[3:0];
            r_s1_lane   <= w_dec.joint;
            r_s1_pos    <= i_frame.position_word;
            r_s1_final  <= n_fin;
            r_s1_time   <= i_frame.arrival_time;
        end
    end

    // bypass the lane written by this beat
    for (genvar j = 0; j < tpr_pkg::OUT_JOINTS; j++) begin : g_joint
        if (j < tpr_pkg::JOINTS) begin : g_live
            assign n_joint[j] = (r_s1_lane == tpr_pkg::JOINT_W'(j)) ? r_s1_pos : w_rd_row[j];
        end else begin : g_zero
            assign n_joint[j] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_status <= r_s1_status;
            if (r_s1_status == tpr_pkg::ST_COMPLETE) begin
                r_out_arm   <= r_s1_arm;
                r_out_point <= r_s1_point;
                for (int j = 0; j < tpr_pkg::OUT_JOINTS; j++) begin
                    r_out_joint[j] <= n_joint[j];
                end
                r_out_final <= r_s1_final;
                r_out_time  <= r_s1_time;
            end else begin
                r_out_arm   <= 1'b0;
                r_out_point <= '0;
                for (int j = 0; j < tpr_pkg::OUT_JOINTS; j++) begin
                    r_out_joint[j] <= '0;
                end
                r_out_final <= 1'b0;
                r_out_time  <= '0;
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.status      = r_out_status;
    assign o_result.arm_index   = r_out_arm;
    assign o_result.point_index = r_out_point;
    assign o_result.joint_zero  = r_out_joint[0];
    assign o_result.joint_one   = r_out_joint[1];
    assign o_result.joint_two   = r_out_joint[2];
    assign o_result.joint_three = r_out_joint[3];
    assign o_result.joint_four  = r_out_joint[4];
    assign o_result.joint_five  = r_out_joint[5];
    assign o_result.final_point = r_out_final;
    assign o_result.point_time  = r_out_time;

endmodule

FILE: sv/tpr_decode.sv
// ----------------------------------------------------------------------------
// tpr_decode
// Frame filter and check chain; splits the motor code into arm and joint.
// ----------------------------------------------------------------------------
module tpr_decode (
    input  logic                         i_bus_index,
    input  logic [10:0]                  i_frame_id,
    input  logic [3:0]                   i_frame_length,
    input  logic [7:0]                   i_point_byte,
    input  logic [7:0]                   i_motor_byte,
    input  logic [10:0]                  i_cfg_frame_id,
    input  logic                         i_cfg_bus,
    output tpr_pkg::t_decode             o_dec
);

    logic [tpr_pkg::ARM_W-1:0] n_arm;
    int                        n_slot;

    always_comb begin
        n_arm  = tpr_pkg::motor_arm(i_motor_byte);
        n_slot = int'(n_arm) * tpr_pkg::POINTS + int'(i_point_byte);

        o_dec.arm   = n_arm;
        o_dec.joint = tpr_pkg::JOINT_W'(int'(i_motor_byte) - int'(n_arm) * tpr_pkg::JOINTS);
        o_dec.slot  = tpr_pkg::SLOT_W'(n_slot);
        o_dec.store = 1'b0;

        if (i_bus_index != i_cfg_bus || i_frame_id != i_cfg_frame_id) begin
            o_dec.status = tpr_pkg::ST_IGNORED;
        end else if (i_frame_length < tpr_pkg::MIN_LENGTH) begin
            o_dec.status = tpr_pkg::ST_SHORT;
        end else if (i_motor_byte >= 8'(tpr_pkg::MOTORS)) begin
            o_dec.status = tpr_pkg::ST_BAD_MOTOR;
        end else if (int'(i_point_byte) >= tpr_pkg::POINTS) begin
            o_dec.status = tpr_pkg::ST_BAD_POINT;
        end else begin
            o_dec.status = tpr_pkg::ST_STORED;
            o_dec.store  = 1'b1;
        end
    end

endmodule

FILE: sv/tpr_joint_ram.sv
// ----------------------------------------------------------------------------
// tpr_joint_ram
// Joint position cache, one row per arm and point, one lane per joint.
// ----------------------------------------------------------------------------
module tpr_joint_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic                          i_re,
    input  logic [tpr_pkg::SLOT_W-1:0]    i_slot,
    input  logic [tpr_pkg::JOINT_W-1:0]   i_lane,
    input  logic [tpr_pkg::POS_W-1:0]     i_wr_data,
    output tpr_pkg::t_joint_row           o_rd_row
);

    tpr_pkg::t_joint_row r_mem [tpr_pkg::SLOTS];
    tpr_pkg::t_joint_row r_rd_row;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < tpr_pkg::JOINTS; j++) begin
            if (i_we && i_lane == tpr_pkg::JOINT_W'(j)) begin
                r_mem[i_slot][j] <= i_wr_data;
            end
        end
        if (i_re) begin
            r_rd_row <= r_mem[i_slot];
        end
    end

    assign o_rd_row = r_rd_row;

endmodule
